@@ rtl/wve_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and field functions of the wavetable voice engine.
package wve_pkg;

	localparam int VOICE_COUNT_DEF   = 32;
	localparam int ROM_ADDR_BITS_DEF = 24;
	localparam int RAMP_TOP_DEF      = 64;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [1:0] FMT_16   = 2'd0;
	localparam logic [1:0] FMT_8    = 2'd1;
	localparam logic [1:0] FMT_ULAW = 2'd2;

	localparam logic [4:0] REG_OSC_CONF   = 5'h00;
	localparam logic [4:0] REG_FREQ       = 5'h01;
	localparam logic [4:0] REG_LSTART_HI  = 5'h02;
	localparam logic [4:0] REG_LSTART_LO  = 5'h03;
	localparam logic [4:0] REG_LEND_HI    = 5'h04;
	localparam logic [4:0] REG_LEND_LO    = 5'h05;
	localparam logic [4:0] REG_ENV_RATE   = 5'h06;
	localparam logic [4:0] REG_ENV_LOW    = 5'h07;
	localparam logic [4:0] REG_ENV_HIGH   = 5'h08;
	localparam logic [4:0] REG_ENV_LEVEL  = 5'h09;
	localparam logic [4:0] REG_POS_HI     = 5'h0a;
	localparam logic [4:0] REG_POS_LO     = 5'h0b;
	localparam logic [4:0] REG_PAN        = 5'h0c;
	localparam logic [4:0] REG_ENV_CONF   = 5'h0d;
	localparam logic [4:0] REG_KEY        = 5'h10;
	localparam logic [4:0] REG_BANK       = 5'h11;

	localparam logic [7:0] KEY_OFF_CODE = 8'h0f;

	typedef struct packed {
		logic [31:0] osc_position;
		logic [31:0] osc_remaining;
		logic [31:0] loop_start;
		logic [31:0] loop_end;
		logic [15:0] freq_step;
		logic [7:0]  bank_select;
		logic [7:0]  osc_flags;
		logic [7:0]  env_flags;
		logic [31:0] env_level;
		logic [31:0] env_low_limit;
		logic [31:0] env_high_limit;
		logic [7:0]  env_rate;
		logic [7:0]  pan_position;
		logic [7:0]  key_control;
		logic        key_down;
		logic [6:0]  click_ramp;
	} voice_t;

	localparam voice_t VOICE_RESET = '{
		osc_flags:    8'h02,
		env_flags:    8'h01,
		pan_position: 8'h7f,
		default:      '0
	};

	typedef struct packed {
		logic [4:0]  voice_out;
		logic        audible;
		logic [23:0] first_addr;
		logic [23:0] second_addr;
		logic [1:0]  format;
		logic [8:0]  fraction;
		logic [14:0] gain_left;
		logic [14:0] gain_right;
	} rsp_t;

	// attenuation of the pan law: 16 minus the top set bit, full cut at zero
	function automatic logic [11:0] pan_law(input logic [7:0] i);
		logic [2:0] top;
		top = '0;
		for (int b = 1; b < 8; b++) begin
			if (i[b]) top = 3'(b);
		end
		pan_law = (i == 8'd0) ? 12'hfff : 12'(5'd16 - {2'b00, top});
	endfunction

	function automatic logic [14:0] vol_law(input logic [11:0] i);
		logic [14:0] mant;
		logic [3:0]  sh;
		mant = {1'b1, i[7:0], 6'b0};
		sh = 4'd15 - i[11:8];
		vol_law = mant >> sh;
	endfunction

	function automatic voice_t write_reg(input voice_t r, input logic [4:0] rg,
			input logic [15:0] d, input logic [6:0] ramp_top);
		voice_t n;
		logic [7:0] hi;
		n = r;
		hi = d[15:8];
		case (rg)
			REG_OSC_CONF:  n.osc_flags = {r.osc_flags[7], hi[6:0]};
			REG_FREQ:      n.freq_step = {d[15:1], 1'b0};
			REG_LSTART_HI: n.loop_start = {d, r.loop_start[15:0]};
			REG_LSTART_LO: n.loop_start = {r.loop_start[31:16], d[15:8], r.loop_start[7:0]};
			REG_LEND_HI:   n.loop_end = {d, r.loop_end[15:0]};
			REG_LEND_LO:   n.loop_end = {r.loop_end[31:16], d[15:8], r.loop_end[7:0]};
			REG_ENV_RATE:  n.env_rate = hi;
			REG_ENV_LOW:   n.env_low_limit = {6'b0, d[7:0], 18'b0};
			REG_ENV_HIGH:  n.env_high_limit = {6'b0, d[7:0], 18'b0};
			REG_ENV_LEVEL: n.env_level = {6'b0, d, 10'b0};
			REG_POS_HI:    n.osc_position = {d, r.osc_position[15:0]};
			REG_POS_LO:    n.osc_position = {r.osc_position[31:16], d[15:3], 3'b0};
			REG_PAN:       n.pan_position = hi;
			REG_ENV_CONF:  n.env_flags = {r.env_flags[7], hi[6:0]};
			REG_KEY: begin
				n.key_control = hi;
				n.key_down = (hi == 8'd0);
				if (hi == 8'd0) begin
					n.click_ramp = ramp_top;
				end else if (hi == KEY_OFF_CODE) begin
					n.osc_flags[1] = 1'b1;
					n.env_flags[1] = 1'b1;
				end
			end
			REG_BANK:      n.bank_select = hi;
			default: ;
		endcase
		write_reg = n;
	endfunction

endpackage

@@ rtl/wve_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces of the wavetable voice engine.
interface wve_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [4:0]  voice;
	logic [4:0]  reg_req;
	logic [15:0] data;
	modport source(output valid, op, voice, reg_req, data, input ready);
	modport sink(input valid, op, voice, reg_req, data, output ready);
endinterface

interface wve_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  voice_out;
	logic        audible;
	logic [23:0] first_addr;
	logic [23:0] second_addr;
	logic [1:0]  format;
	logic [8:0]  fraction;
	logic [14:0] gain_left;
	logic [14:0] gain_right;
	modport source(output valid, voice_out, audible, first_addr, second_addr, format,
		fraction, gain_left, gain_right, input ready);
	modport sink(input valid, voice_out, audible, first_addr, second_addr, format,
		fraction, gain_left, gain_right, output ready);
endinterface

@@ rtl/wve_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wve_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule

@@ rtl/wve_out_reg.sv @@
`timescale 1ns / 1ps
// Result holding register that drives the result channel.
module wve_out_reg
	import wve_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic ld,
	input  rsp_t res,
	output logic free,
	wve_rsp_if.source rsp
);
	logic valid_q;
	rsp_t res_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld && free) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld && free) res_q <= res;
	end

	assign rsp.valid       = valid_q;
	assign rsp.voice_out   = res_q.voice_out;
	assign rsp.audible     = res_q.audible;
	assign rsp.first_addr  = res_q.first_addr;
	assign rsp.second_addr = res_q.second_addr;
	assign rsp.format      = res_q.format;
	assign rsp.fraction    = res_q.fraction;
	assign rsp.gain_left   = res_q.gain_left;
	assign rsp.gain_right  = res_q.gain_right;
endmodule

@@ rtl/wavetable_voice_engine.sv @@
`timescale 1ns / 1ps
// Top level: voice record RAM, read-modify-write sequencer and result register.
//  channel | dir | handshake       | payload
//  req     | in  | valid / ready   | op, voice, reg_req, data
//  rsp     | out | valid / ready   | voice_out, audible, addresses, format, fraction, gains
//  cfg     | in  | cfg_we          | cfg_wdata = last_active_voice
// A request passes through RAM read, oscillator step, wrap and envelope step, and
// envelope wrap with write-back and result load; ready stays low until it is done.
// A result waiting in the output register does not block the next request until the
// next write-back, which holds in its last cycle while the register is full.
// Reset: last_active_voice is 31; per-voice valid bits clear so records read as reset.
module wavetable_voice_engine
	import wve_pkg::*;
#(
	parameter int VOICE_COUNT   = VOICE_COUNT_DEF,
	parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF,
	parameter int RAMP_TOP      = RAMP_TOP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata,
	wve_req_if.sink    req,
	wve_rsp_if.source  rsp
);
	localparam int IDXW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam logic [27:0] ADDR_MASK = 28'((64'd1 << ROM_ADDR_BITS) - 64'd1);
	localparam logic [6:0] RAMP_FULL = 7'(RAMP_TOP);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_A    = 2'd1;
	localparam logic [1:0] ST_B    = 2'd2;
	localparam logic [1:0] ST_C    = 2'd3;

	logic [1:0] state_q;
	logic [4:0] lav_q;
	logic [VOICE_COUNT-1:0] vld_q;
	logic op_q;
	logic [4:0] voice_q, reg_q;
	logic [15:0] data_q;
	voice_t rec_q;
	logic wr_q, step_q, env_go_q;
	logic [31:0] env_left_q;
	logic [14:0] vol_l_q, vol_r_q;
	logic [6:0] ramp_q;
	rsp_t res_q;

	logic accept, out_free, ram_we;
	logic [IDXW-1:0] idx;
	logic [$bits(voice_t)-1:0] ram_rdata;
	logic in_range;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign idx = voice_q[IDXW-1:0];
	assign in_range = (32'(voice_q) < 32'(VOICE_COUNT));
	assign ram_we = (state_q == ST_C) && out_free && wr_q;

	function automatic logic [23:0] rom_addr(input logic [7:0] bank, input logic [19:0] p);
		logic [27:0] a;
		a = {bank, p} & ADDR_MASK;
		rom_addr = a[23:0];
	endfunction

	// read stage: record, result fields and first oscillator step
	voice_t r, a_rec;
	logic playing, run;
	logic [19:0] cur, nxt;
	logic [1:0] fmt;
	logic [11:0] volacc;
	logic [12:0] dl, dr;
	logic [31:0] inc;
	rsp_t a_res;

	always_comb begin
		r = vld_q[idx] ? voice_t'(ram_rdata) : VOICE_RESET;
		playing = r.key_down && !r.osc_flags[1];
		run = (op_q == OP_TICK) && in_range && (voice_q <= lav_q)
			&& (playing || r.click_ramp != 7'd0);
		cur = r.osc_position[31:12];
		inc = {14'b0, r.freq_step, 2'b00};
		if (r.osc_flags[0]) fmt = FMT_ULAW;
		else if (r.osc_flags[2]) fmt = FMT_8;
		else fmt = FMT_16;
		if (fmt != FMT_16) begin
			nxt = cur + 20'd1;
		end else if (r.key_down && r.osc_flags[3] && !r.osc_flags[4]
				&& $signed(r.osc_remaining) < $signed(inc)) begin
			nxt = r.loop_start[31:12];
		end else begin
			nxt = cur + 20'd2;
		end
		volacc = r.env_level[25:14];
		dl = {1'b0, volacc} - {1'b0, pan_law(~r.pan_position)};
		dr = {1'b0, volacc} - {1'b0, pan_law(r.pan_position)};

		a_res = '0;
		a_res.voice_out = voice_q;
		if (run) begin
			a_res.audible = 1'b1;
			a_res.first_addr = rom_addr(r.bank_select, cur);
			a_res.second_addr = rom_addr(r.bank_select, nxt);
			a_res.format = fmt;
			a_res.fraction = r.osc_position[11:3];
		end

		a_rec = r;
		if (op_q == OP_WRITE) begin
			a_rec = write_reg(r, reg_q, data_q, RAMP_FULL);
		end else if (run) begin
			if (playing) begin
				if (r.click_ramp < RAMP_FULL) a_rec.click_ramp = r.click_ramp + 7'd1;
				if (r.osc_flags[6]) begin
					a_rec.osc_position = r.osc_position - inc;
					a_rec.osc_remaining = a_rec.osc_position - r.loop_start;
				end else begin
					a_rec.osc_position = r.osc_position + inc;
					a_rec.osc_remaining = r.loop_end - a_rec.osc_position;
				end
			end else begin
				a_rec.click_ramp = r.click_ramp - 7'd1;
			end
		end
	end

	// second stage: oscillator wrap and first envelope step
	voice_t b_rec;
	logic [7:0] of2;
	logic [31:0] add, b_left;
	always_comb begin
		b_rec = rec_q;
		of2 = rec_q.osc_flags;
		if (!($signed(rec_q.osc_remaining) > 0)) begin
			if (of2[3]) begin
				if (of2[4]) of2[6] = !of2[6];
				b_rec.osc_flags = of2;
				if (of2[6]) begin
					b_rec.osc_position = rec_q.loop_end + rec_q.osc_remaining;
					b_rec.osc_remaining = b_rec.osc_position - rec_q.loop_start;
				end else begin
					b_rec.osc_position = rec_q.loop_start - rec_q.osc_remaining;
					b_rec.osc_remaining = rec_q.loop_end - b_rec.osc_position;
				end
			end else begin
				b_rec.key_down = 1'b0;
				b_rec.osc_flags = of2 | 8'h02;
				b_rec.osc_position = of2[6] ? rec_q.loop_start : rec_q.loop_end;
			end
		end
		case (rec_q.env_rate[7:6])
			2'd0: add = {17'b0, rec_q.env_rate[5:0], 9'b0};
			2'd1: add = {24'b0, rec_q.env_rate[5:0], 2'b0};
			default: add = '0;
		endcase
		if (rec_q.env_flags[6]) begin
			b_rec.env_level = rec_q.env_level - add;
			b_left = b_rec.env_level - rec_q.env_low_limit;
		end else begin
			b_rec.env_level = rec_q.env_level + add;
			b_left = rec_q.env_high_limit - b_rec.env_level;
		end
		if (rec_q.env_flags[1:0] != 2'b00) begin
			b_rec.env_level = rec_q.env_level;
		end
	end

	// last stage: envelope wrap or done
	voice_t c_rec;
	logic [31:0] acc, rt, lo, hi;
	always_comb begin
		c_rec = rec_q;
		acc = rec_q.env_level;
		rt = {24'b0, rec_q.env_rate};
		lo = rec_q.env_low_limit;
		hi = rec_q.env_high_limit;
		if (step_q && env_go_q && !($signed(env_left_q) > 0) && !rec_q.osc_flags[2]) begin
			if (rec_q.env_flags[3]) begin
				case ({rec_q.env_flags[4], rec_q.env_flags[6]})
					2'b00: c_rec.env_level = lo - (hi - (acc + rt));
					2'b01: c_rec.env_level = hi + ((acc - rt) - lo);
					2'b10: c_rec.env_level = hi + (hi - (acc + rt));
					default: c_rec.env_level = lo - ((acc - rt) - lo);
				endcase
			end else begin
				c_rec.env_flags = rec_q.env_flags | 8'h01;
			end
		end
	end

	logic [21:0] prod_l, prod_r;
	assign prod_l = vol_l_q * ramp_q;
	assign prod_r = vol_r_q * ramp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lav_q <= 5'd31;
			vld_q <= '0;
		end else begin
			if (cfg_we) lav_q <= cfg_wdata;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_A;
				ST_A:    state_q <= ST_B;
				ST_B:    state_q <= ST_C;
				ST_C: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (wr_q) vld_q[idx] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q <= req.op;
					voice_q <= req.voice;
					reg_q <= req.reg_req;
					data_q <= req.data;
				end
			end
			ST_A: begin
				rec_q <= a_rec;
				res_q <= a_res;
				wr_q <= run || ((op_q == OP_WRITE) && in_range);
				step_q <= run && playing;
				// zero ramp silences the gains of writes and silent ticks
				ramp_q <= run ? r.click_ramp : 7'd0;
				vol_l_q <= ($signed(dl) > 0) ? vol_law(dl[11:0]) : '0;
				vol_r_q <= ($signed(dr) > 0) ? vol_law(dr[11:0]) : '0;
			end
			ST_B: begin
				if (step_q) begin
					rec_q <= b_rec;
					env_left_q <= b_left;
					env_go_q <= (rec_q.env_flags[1:0] == 2'b00);
				end else begin
					env_go_q <= 1'b0;
				end
				res_q.gain_left <= prod_l[20:6];
				res_q.gain_right <= prod_r[20:6];
			end
			default: ;
		endcase
	end

	wve_ram #(
		.WIDTH($bits(voice_t)),
		.DEPTH(VOICE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx),
		.wdata (c_rec),
		.re    (accept),
		.raddr (req.voice[IDXW-1:0]),
		.rdata (ram_rdata)
	);

	wve_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (state_q == ST_C),
		.res    (res_q),
		.free   (out_free),
		.rsp    (rsp)
	);

	a_write_in_last: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == ST_C)
		else $error("record written outside write-back stage");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_A)
		else $error("accepted request did not enter read stage");
	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> in_range)
		else $error("write-back to voice beyond voice count");
	a_step_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_C && step_q) |-> wr_q)
		else $error("stepped voice not written back");
endmodule
